// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants for the source text tokenizer: token kinds, error codes,
// default widths and result queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;

    // most words a single input byte can produce
    localparam int MAX_RES     = 3;
    localparam int RBUF_DEPTH  = 4;

    localparam logic [4:0] K_LPAREN = 5'd0;
    localparam logic [4:0] K_RPAREN = 5'd1;
    localparam logic [4:0] K_LBRACE = 5'd2;
    localparam logic [4:0] K_RBRACE = 5'd3;
    localparam logic [4:0] K_COMMA  = 5'd4;
    localparam logic [4:0] K_DOT    = 5'd5;
    localparam logic [4:0] K_MINUS  = 5'd6;
    localparam logic [4:0] K_PLUS   = 5'd7;
    localparam logic [4:0] K_SEMI   = 5'd8;
    localparam logic [4:0] K_STAR   = 5'd9;
    localparam logic [4:0] K_EQ_EQ  = 5'd10;
    localparam logic [4:0] K_EQ     = 5'd11;
    localparam logic [4:0] K_STRING = 5'd18;
    localparam logic [4:0] K_NUMBER = 5'd19;
    localparam logic [4:0] K_IDENT  = 5'd20;
    localparam logic [4:0] K_LET    = 5'd21;
    localparam logic [4:0] K_EOF    = 5'd22;
    localparam logic [4:0] K_ERROR  = 5'd23;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM_STR = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/stt_if.sv =====
// ----------------------------------------------------------------------------
// stt_if
// Valid/ready channels of the tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_marker;

    modport source (output valid, output byte_in, output end_marker, input ready);
    modport sink   (input valid, input byte_in, input end_marker, output ready);
endinterface

interface stt_out_if #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] lexeme_length;
    logic [LINE_BITS-1:0]   line_number;
    logic [1:0]             error_kind;
    logic                   last_in_run;

    modport source (output valid, output kind, output start_offset, output lexeme_length,
                    output line_number, output error_kind, output last_in_run,
                    input ready);
    modport sink   (input valid, input kind, input start_offset, input lexeme_length,
                    input line_number, input error_kind, input last_in_run,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// Scanner state and single-pass token logic: for each accepted byte or end
// marker it forms up to three token words and advances the scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16,
    parameter int TOK_W       = 5 + 2 * OFFSET_BITS + LINE_BITS + 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_acc,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_end,
    output logic      [1:0]       o_res_cnt,
    output logic      [TOK_W-1:0] o_res [stt_pkg::MAX_RES]
);
    import stt_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LINE_BITS;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        M_IDLE, M_OPER, M_STRING, M_NUMBER, M_NUMDOT, M_IDENT, M_DISCARD
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [1:0]     r_op, n_op;
    logic [OB-1:0]  r_pos, n_pos;
    logic [OB-1:0]  r_start, n_start;
    logic [LB-1:0]  r_line, n_line;
    logic [2:0]     r_kw, n_kw;
    logic           r_frac, n_frac;

    logic [4:0]     e_kind  [MAX_RES];
    logic [OB-1:0]  e_start [MAX_RES];
    logic [OB-1:0]  e_len   [MAX_RES];
    logic [1:0]     e_err   [MAX_RES];
    logic [1:0]     cnt;

    logic [OB-1:0]  cur_inc;
    logic [OB-1:0]  dot_pos;
    logic [LB-1:0]  line_inc;
    logic           fresh;
    logic           single_ok;
    logic [4:0]     single_kind;
    logic           op_ok;
    logic [1:0]     op_idx;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    // progress through "let": 1..3 matched so far, 4 no match
    function automatic logic [2:0] kw_next(input logic [2:0] prog, input logic [7:0] c);
        if (prog == 3'd0 && c == 8'h6C) return 3'd1;
        if (prog == 3'd1 && c == 8'h65) return 3'd2;
        if (prog == 3'd2 && c == 8'h74) return 3'd3;
        return 3'd4;
    endfunction

    function automatic logic [OB-1:0] len_to(input logic [OB-1:0] end_v,
                                             input logic [OB-1:0] start_v);
        return (end_v >= start_v) ? end_v - start_v : '0;
    endfunction

    assign cur_inc  = (&r_pos)  ? r_pos  : r_pos + OB'(1);
    assign line_inc = (&r_line) ? r_line : r_line + LB'(1);
    assign dot_pos  = (r_pos > r_start) ? r_pos - OB'(1) : r_pos;

    always_comb begin
        single_ok   = 1'b1;
        single_kind = K_LPAREN;
        case (i_byte)
            8'h28:   single_kind = K_LPAREN;
            8'h29:   single_kind = K_RPAREN;
            8'h7B:   single_kind = K_LBRACE;
            8'h7D:   single_kind = K_RBRACE;
            8'h2C:   single_kind = K_COMMA;
            8'h2E:   single_kind = K_DOT;
            8'h2D:   single_kind = K_MINUS;
            8'h2B:   single_kind = K_PLUS;
            8'h3B:   single_kind = K_SEMI;
            8'h2A:   single_kind = K_STAR;
            default: single_ok   = 1'b0;
        endcase
        op_ok  = 1'b1;
        op_idx = 2'd0;
        case (i_byte)
            CH_EQ:   op_idx = 2'd0;
            CH_BANG: op_idx = 2'd1;
            CH_LT:   op_idx = 2'd2;
            CH_GT:   op_idx = 2'd3;
            default: op_ok  = 1'b0;
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_op    = r_op;
        n_pos   = r_pos;
        n_start = r_start;
        n_line  = r_line;
        n_kw    = r_kw;
        n_frac  = r_frac;
        cnt     = 2'd0;
        fresh   = 1'b0;
        for (int i = 0; i < MAX_RES; i++) begin
            e_kind[i]  = K_EOF;
            e_start[i] = '0;
            e_len[i]   = '0;
            e_err[i]   = E_NONE;
        end

        if (i_end) begin
            // flush whatever is pending, then the end-of-file word
            case (r_mode)
                M_OPER: begin
                    e_kind[cnt]  = K_EQ + {2'b00, r_op, 1'b0};
                    e_start[cnt] = r_start;
                    e_len[cnt]   = len_to(r_pos, r_start);
                    cnt          = cnt + 2'd1;
                end
                M_STRING: begin
                    e_kind[cnt]  = K_ERROR;
                    e_start[cnt] = r_start;
                    e_len[cnt]   = len_to(r_pos, r_start);
                    e_err[cnt]   = E_UNTERM_STR;
                    cnt          = cnt + 2'd1;
                end
                M_NUMBER: begin
                    e_kind[cnt]  = K_NUMBER;
                    e_start[cnt] = r_start;
                    e_len[cnt]   = len_to(r_pos, r_start);
                    cnt          = cnt + 2'd1;
                end
                M_NUMDOT: begin
                    e_kind[cnt]  = K_NUMBER;
                    e_start[cnt] = r_start;
                    e_len[cnt]   = len_to(dot_pos, r_start);
                    cnt          = cnt + 2'd1;
                    e_kind[cnt]  = K_DOT;
                    e_start[cnt] = dot_pos;
                    e_len[cnt]   = OB'(1);
                    cnt          = cnt + 2'd1;
                end
                M_IDENT: begin
                    e_kind[cnt]  = (r_kw == 3'd3) ? K_LET : K_IDENT;
                    e_start[cnt] = r_start;
                    e_len[cnt]   = len_to(r_pos, r_start);
                    cnt          = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            e_kind[cnt]  = K_EOF;
            e_start[cnt] = r_pos;
            e_len[cnt]   = '0;
            cnt          = cnt + 2'd1;
            n_mode  = M_IDLE;
            n_op    = 2'd0;
            n_pos   = '0;
            n_start = '0;
            n_line  = LB'(1);
            n_kw    = 3'd0;
            n_frac  = 1'b0;
        end else begin
            case (r_mode)
                M_OPER: begin
                    if (i_byte == CH_EQ) begin
                        e_kind[cnt]  = K_EQ_EQ + {2'b00, r_op, 1'b0};
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(cur_inc, r_start);
                        cnt          = cnt + 2'd1;
                        n_mode       = M_IDLE;
                    end else begin
                        e_kind[cnt]  = K_EQ + {2'b00, r_op, 1'b0};
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(r_pos, r_start);
                        cnt          = cnt + 2'd1;
                        fresh        = 1'b1;
                    end
                end
                M_STRING: begin
                    if (i_byte == CH_QUOTE) begin
                        e_kind[cnt]  = K_STRING;
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(cur_inc, r_start);
                        cnt          = cnt + 2'd1;
                        n_mode       = M_IDLE;
                    end else if (i_byte == CH_LF) begin
                        n_line = line_inc;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(i_byte)) begin
                        n_mode = M_NUMBER;
                    end else if (i_byte == CH_DOT && !r_frac) begin
                        n_mode = M_NUMDOT;
                    end else begin
                        e_kind[cnt]  = K_NUMBER;
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(r_pos, r_start);
                        cnt          = cnt + 2'd1;
                        fresh        = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(i_byte)) begin
                        n_frac = 1'b1;
                        n_mode = M_NUMBER;
                    end else begin
                        e_kind[cnt]  = K_NUMBER;
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(dot_pos, r_start);
                        cnt          = cnt + 2'd1;
                        e_kind[cnt]  = K_DOT;
                        e_start[cnt] = dot_pos;
                        e_len[cnt]   = OB'(1);
                        cnt          = cnt + 2'd1;
                        fresh        = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(i_byte) || is_digit(i_byte)) begin
                        n_kw = kw_next(r_kw, i_byte);
                    end else begin
                        e_kind[cnt]  = (r_kw == 3'd3) ? K_LET : K_IDENT;
                        e_start[cnt] = r_start;
                        e_len[cnt]   = len_to(r_pos, r_start);
                        cnt          = cnt + 2'd1;
                        fresh        = 1'b1;
                    end
                end
                M_DISCARD: begin
                    n_mode = M_DISCARD;
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase

            // start a new lexeme at this byte
            if (fresh) begin
                n_mode  = M_IDLE;
                n_start = r_pos;
                if (single_ok) begin
                    e_kind[cnt]  = single_kind;
                    e_start[cnt] = r_pos;
                    e_len[cnt]   = OB'(1);
                    cnt          = cnt + 2'd1;
                end else if (op_ok) begin
                    n_op   = op_idx;
                    n_mode = M_OPER;
                end else if (i_byte == CH_QUOTE) begin
                    n_mode = M_STRING;
                end else if (i_byte == CH_SP || i_byte == CH_CR || i_byte == CH_TAB) begin
                    n_mode = M_IDLE;
                end else if (i_byte == CH_LF) begin
                    n_line = line_inc;
                end else if (is_digit(i_byte)) begin
                    n_frac = 1'b0;
                    n_mode = M_NUMBER;
                end else if (is_alpha(i_byte)) begin
                    n_kw   = kw_next(3'd0, i_byte);
                    n_mode = M_IDENT;
                end else begin
                    e_kind[cnt]  = K_ERROR;
                    e_start[cnt] = r_pos;
                    e_len[cnt]   = OB'(1);
                    e_err[cnt]   = E_UNEXPECTED;
                    cnt          = cnt + 2'd1;
                    n_mode       = M_DISCARD;
                end
            end
            n_pos = cur_inc;
        end
    end

    always_comb begin
        o_res_cnt = cnt;
        for (int i = 0; i < MAX_RES; i++) begin
            o_res[i] = {e_kind[i], e_start[i], e_len[i], r_line, e_err[i],
                        (2'(i) == cnt - 2'd1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_op    <= 2'd0;
            r_pos   <= '0;
            r_start <= '0;
            r_line  <= LB'(1);
            r_kw    <= 3'd0;
            r_frac  <= 1'b0;
        end else if (i_acc) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_line  <= n_line;
            r_kw    <= n_kw;
            r_frac  <= n_frac;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stt_rbuf.sv =====
// ----------------------------------------------------------------------------
// stt_rbuf
// Small token queue: takes up to three words per cycle from the scanner and
// hands out one word per cycle while the output channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_rbuf #(
    parameter int WIDTH = 56
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_wr_n,
    input  wire logic [WIDTH-1:0] i_wr_data [stt_pkg::MAX_RES],
    output logic                  o_wr_ready,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ready,
    output logic      [WIDTH-1:0] o_rd_data
);
    import stt_pkg::*;

    localparam int PW = $clog2(RBUF_DEPTH);
    localparam int CW = $clog2(RBUF_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [RBUF_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    // room for a full burst from the next byte
    assign o_wr_ready = (r_count <= CW'(RBUF_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < i_wr_n) begin
                r_mem[r_wr_ptr + PW'(k)] <= i_wr_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_wr_n);
            r_rd_ptr <= r_rd_ptr + PW'(pop);
            r_count  <= r_count + CW'(i_wr_n) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/source_text_tokenizer.sv =====
// A token word is queued as the byte that ends it is accepted. Throughput: one byte
// per cycle; a byte may yield up to three words, drained one per cycle while the
// sink is ready from a four-word queue; i_src.ready is low while it holds two or more.
// Reset: synchronous, active low; scanner returns to idle at offset 0, line 1,
// and the queue empties.
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: source bytes in, tokens out as kind, offset,
// length and line.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stt_in_if.sink     i_src,
    stt_out_if.source  o_tok
);
    import stt_pkg::*;

    localparam int TOK_W = 5 + 2 * OFFSET_BITS + LINE_BITS + 3;

    logic             acc;
    logic             wr_ready;
    logic [1:0]       res_cnt;
    logic [1:0]       wr_n;
    logic [TOK_W-1:0] res [MAX_RES];
    logic [TOK_W-1:0] head;

    assign i_src.ready = wr_ready;
    assign acc         = i_src.valid && wr_ready;
    assign wr_n        = acc ? res_cnt : 2'd0;

    stt_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .TOK_W       (TOK_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_byte    (i_src.byte_in),
        .i_end     (i_src.end_marker),
        .o_res_cnt (res_cnt),
        .o_res     (res)
    );

    stt_rbuf #(
        .WIDTH (TOK_W)
    ) u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_n     (wr_n),
        .i_wr_data  (res),
        .o_wr_ready (wr_ready),
        .o_rd_valid (o_tok.valid),
        .i_rd_ready (o_tok.ready),
        .o_rd_data  (head)
    );

    assign {o_tok.kind, o_tok.start_offset, o_tok.lexeme_length, o_tok.line_number,
            o_tok.error_kind, o_tok.last_in_run} = head;

endmodule

`default_nettype wire

// ===== rtl/core/stt_checker.sv =====
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the token output of the tokenizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   i_ready,
    input wire logic [4:0]             i_kind,
    input wire logic [OFFSET_BITS-1:0] i_start,
    input wire logic [OFFSET_BITS-1:0] i_len,
    input wire logic [LINE_BITS-1:0]   i_line,
    input wire logic [1:0]             i_err,
    input wire logic                   i_last
);
    import stt_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_start)
            && $stable(i_len) && $stable(i_err) && $stable(i_last))
        else $error("token word changed while stalled");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_kind == K_ERROR) == (i_err != E_NONE)))
        else $error("error code does not match token kind");

    // end of file closes the run with an empty lexeme
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == K_EOF |-> i_last && i_len == '0)
        else $error("end-of-file word malformed");

    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_line != '0)
        else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
) u_stt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_tok.valid),
    .i_ready (o_tok.ready),
    .i_kind  (o_tok.kind),
    .i_start (o_tok.start_offset),
    .i_len   (o_tok.lexeme_length),
    .i_line  (o_tok.line_number),
    .i_err   (o_tok.error_kind),
    .i_last  (o_tok.last_in_run)
);

`default_nettype wire
